// ===== src/nms_pkg.sv =====
// Shared types and constants for the neighbour mean smoothing block.
package nms_pkg;

  // Input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;
  localparam int unsigned CFG_W = 11;

  // Result field widths
  localparam int unsigned OUT_W = 20;
  localparam int unsigned POS_W = 10;

  // Neighbour count field and the nonzero counts that can occur
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_ONE   = 4'd1;
  localparam logic [CNT_W-1:0] CNT_TWO   = 4'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 4'd3;
  localparam logic [CNT_W-1:0] CNT_FIVE  = 4'd5;
  localparam logic [CNT_W-1:0] CNT_EIGHT = 4'd8;

  // Mean datapath: sum magnitude is capped at 2^19, past which every count saturates
  localparam int unsigned M_W   = 20;
  localparam int unsigned Q_W   = 23;
  localparam logic [M_W-1:0] MAG_CAP = 20'h80000;
  localparam logic [Q_W-1:0] POS_LIM = 23'h07FFFF;
  localparam logic [Q_W-1:0] NEG_LIM = 23'h080000;
  // floor(x/3) = (x * ceil(2^25/3)) >> 25 for x < 2^25
  localparam int unsigned RCP_W  = 24;
  localparam int unsigned RCP_SH = 25;
  localparam logic [RCP_W-1:0] RECIP3 = 24'd11184811;

  // Which sides of the centre hold matrix positions
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nms_edge_t;

  // Control that travels with the neighbour values from front to back
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } nms_tag_t;

endpackage

// ===== src/neighbour_mean_smoothing_top.sv =====
// Top level of the 3x3 neighbour mean filter (centre excluded).
// Samples enter in raster order at one transaction per clock unless the full queue stalls the
// window stage; the line store is one memory of MAX_COLS entries holding the two previous rows,
// read and rewritten once per transaction. The pipeline holds the window stage, a two-entry
// queue and four back-end stages (sum, magnitude, divide-by-count multiply, saturate/output).
// A result appears frame_cols+1 transactions after its sample; after the last sample, drain
// transactions (op = 1) push out the remaining results, the final one flagged by frame_last,
// after which a new frame starts. Drain transactions sent before the last sample are accepted
// and ignored. Writing frame_rows or frame_cols (register 0 and 1) restarts the frame and must
// only happen while the block is idle.
module neighbour_mean_smoothing_top import nms_pkg::*; #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] mean_tenths_o,
  output logic [POS_W-1:0]        out_row_o,
  output logic [POS_W-1:0]        out_col_o,
  output logic                    frame_last_o
);

  localparam int unsigned NB_W = 8 * SAMPLE_BITS;
  localparam int unsigned QW   = NB_W + $bits(nms_tag_t);

  logic            push, full, q_valid, pop;
  logic [NB_W-1:0] push_data, q_data;
  nms_tag_t        push_tag, q_tag;
  logic [QW-1:0]   q_out;

  // Window front end
  nms_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sample_i   (sample_i),
    .push_o     (push),
    .push_data_o(push_data),
    .push_tag_o (push_tag),
    .full_i     (full)
  );

  // Decoupling queue
  nms_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_tag, push_data}),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (q_out)
  );

  assign q_tag  = q_out[QW-1:NB_W];
  assign q_data = q_out[NB_W-1:0];

  // Mean back end
  nms_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_tag_i      (q_tag),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_tenths_o(mean_tenths_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o)
  );

endmodule

// ===== src/nms_queue.sv =====
// Two-entry queue between the front (window) and back (mean) parts.
module nms_queue import nms_pkg::*; #(
  parameter int unsigned WIDTH = 152
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Front must respect full, back must respect empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

endmodule

// ===== src/nms_front.sv =====
// Front part: config, raster counters, line stores and 3x3 window, neighbour selection.
module nms_front import nms_pkg::*; #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                     push_o,
  output logic [8*SAMPLE_BITS-1:0] push_data_o,
  output nms_tag_t                 push_tag_o,
  input  logic                     full_i
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RIN_W  = $clog2(MAX_ROWS + 2);
  localparam int unsigned CDIM_W = $clog2(MAX_COLS + 1);
  localparam int unsigned RDIM_W = $clog2(MAX_ROWS + 1);

  function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v,
                                            input logic [31:0] mx);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) return 32'd1;
    if (w > mx) return mx;
    return w;
  endfunction

  // Configuration and position counters
  logic [RDIM_W-1:0] rows_q;
  logic [CDIM_W-1:0] cols_q;
  logic [RIN_W-1:0]  in_row_q;
  logic [COL_W-1:0]  in_col_q;
  logic [ROW_W-1:0]  em_row_q;
  logic [COL_W-1:0]  em_col_q;

  // Window stage
  logic              f_vld_q;
  logic              f_emit_q;
  logic              f_first_q;
  logic [COL_W-1:0]  f_col_q;
  logic [SB-1:0]     f_val_q;
  nms_edge_t         f_edge_q;
  logic [POS_W-1:0]  f_row_out_q;
  logic [POS_W-1:0]  f_col_out_q;
  logic              f_last_q;
  logic [2*SB-1:0]   rd_q;
  logic [2:0][2:0][SB-1:0] win_q, win_d;
  logic [2*SB-1:0]   line_mem [MAX_COLS];

  logic cfg_we, acc, load, drop, all_in, emit, col_wrap;
  logic em_last_row, em_last_col, em_last;
  logic f_done, fire, fwd;
  nms_edge_t edge_d;
  logic [2*SB-1:0] wr_data;
  logic [2:0][2:0][SB-1:0] view;
  logic [7:0][SB-1:0] nbv, nb_out;
  logic [7:0] nbm;
  logic [CNT_W-1:0] cnt;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // Classify the incoming transaction
  always_comb begin
    all_in      = 32'(in_row_q) >= 32'(rows_q);
    drop        = !all_in && (op_i == OP_DRAIN);
    emit        = (32'(in_row_q) >= 32'd2) || ((in_row_q == RIN_W'(1)) && (in_col_q != '0));
    col_wrap    = (32'(in_col_q) + 32'd1) >= 32'(cols_q);
    em_last_row = (32'(em_row_q) + 32'd1) >= 32'(rows_q);
    em_last_col = (32'(em_col_q) + 32'd1) >= 32'(cols_q);
    em_last     = em_last_row && em_last_col;
    edge_d.up   = (em_row_q != '0);
    edge_d.dn   = !em_last_row;
    edge_d.lf   = (em_col_q != '0);
    edge_d.rt   = !em_last_col;
  end

  assign f_done     = !f_emit_q || !full_i;
  assign fire       = f_vld_q && f_done;
  assign in_ready_o = !f_vld_q || f_done;
  assign acc        = in_valid_i && in_ready_o;
  assign load       = acc && !drop;

  // Position counters; a config write or the final result restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= RDIM_W'(1);
      cols_q   <= CDIM_W'(1);
      in_row_q <= '0;
      in_col_q <= '0;
      em_row_q <= '0;
      em_col_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_FRAME_ROWS: rows_q <= RDIM_W'(clamp_dim(cfg_data_i, 32'(MAX_ROWS)));
        REG_FRAME_COLS: cols_q <= CDIM_W'(clamp_dim(cfg_data_i, 32'(MAX_COLS)));
        default: ;
      endcase
      in_row_q <= '0;
      in_col_q <= '0;
      em_row_q <= '0;
      em_col_q <= '0;
    end else if (load) begin
      if (emit && em_last) begin
        in_row_q <= '0;
        in_col_q <= '0;
        em_row_q <= '0;
        em_col_q <= '0;
      end else begin
        if (col_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RIN_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
        if (emit) begin
          if (em_last_col) begin
            em_col_q <= '0;
            em_row_q <= em_row_q + ROW_W'(1);
          end else begin
            em_col_q <= em_col_q + COL_W'(1);
          end
        end
      end
    end
  end

  // Window stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (load) begin
      f_vld_q <= 1'b1;
    end else if (fire) begin
      f_vld_q <= 1'b0;
    end
  end

  // Window stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      f_emit_q    <= emit;
      f_first_q   <= (in_col_q == '0);
      f_col_q     <= in_col_q;
      f_val_q     <= all_in ? '0 : sample_i;
      f_edge_q    <= edge_d;
      f_row_out_q <= POS_W'(em_row_q);
      f_col_out_q <= POS_W'(em_col_q);
      f_last_q    <= em_last;
    end
  end

  // Line stores: entry holds {two rows back, one row back}; read-modify-write per column
  assign wr_data = {rd_q[SB-1:0], f_val_q};
  assign fwd     = fire && (f_col_q == in_col_q);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      line_mem[f_col_q] <= wr_data;
    end
    if (load) begin
      rd_q <= fwd ? wr_data : line_mem[in_col_q];
    end
  end

  // Window shift and the 3x3 view centred on the result position
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = rd_q[2*SB-1:SB];
    win_d[1][2] = rd_q[SB-1:0];
    win_d[2][2] = f_val_q;
    for (int r = 0; r < 3; r++) begin
      if (f_first_q) begin
        view[r][0] = win_q[r][1];
        view[r][1] = win_q[r][2];
        view[r][2] = '0;
      end else begin
        view[r] = win_d[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (fire) begin
      win_q <= win_d;
    end
  end

  // Neighbours inside the matrix, zero elsewhere, and their count
  always_comb begin
    nbm[0] = f_edge_q.up && f_edge_q.lf;
    nbm[1] = f_edge_q.up;
    nbm[2] = f_edge_q.up && f_edge_q.rt;
    nbm[3] = f_edge_q.lf;
    nbm[4] = f_edge_q.rt;
    nbm[5] = f_edge_q.dn && f_edge_q.lf;
    nbm[6] = f_edge_q.dn;
    nbm[7] = f_edge_q.dn && f_edge_q.rt;
    nbv[0] = view[0][0];
    nbv[1] = view[0][1];
    nbv[2] = view[0][2];
    nbv[3] = view[1][0];
    nbv[4] = view[1][2];
    nbv[5] = view[2][0];
    nbv[6] = view[2][1];
    nbv[7] = view[2][2];
    cnt = '0;
    for (int k = 0; k < 8; k++) begin
      nb_out[k] = nbm[k] ? nbv[k] : '0;
      cnt       = cnt + CNT_W'(nbm[k]);
    end
  end

  assign push_o          = f_vld_q && f_emit_q && !full_i;
  assign push_data_o     = nb_out;
  assign push_tag_o.cnt  = cnt;
  assign push_tag_o.row  = f_row_out_q;
  assign push_tag_o.col  = f_col_out_q;
  assign push_tag_o.last = f_last_q;

  // A stalled window stage keeps its transaction
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_vld_q && !f_done && !cfg_we) |=> (f_vld_q && $stable(f_col_q)))
    else $error("window stage lost a stalled transaction");
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_row_q) <= (32'(rows_q) + 32'd1))
    else $error("input row counter ran past the drain row");
  a_count_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cnt == '0 || cnt == CNT_ONE || cnt == CNT_TWO || cnt == CNT_THREE ||
                cnt == CNT_FIVE || cnt == CNT_EIGHT))
    else $error("impossible neighbour count");

endmodule

// ===== src/nms_back.sv =====
// Back part: neighbour sum, rounded division by the count, saturation, output register.
module nms_back import nms_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  logic [8*SAMPLE_BITS-1:0] q_data_i,
  input  nms_tag_t                 q_tag_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [OUT_W-1:0]  mean_tenths_o,
  output logic [POS_W-1:0]         out_row_o,
  output logic [POS_W-1:0]         out_col_o,
  output logic                     frame_last_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUM_W = SB + 3;
  localparam int unsigned EXT_W = (SUM_W > M_W) ? SUM_W : M_W;
  localparam int unsigned PRD_W = Q_W + RCP_W;

  logic b1_vld_q, b2_vld_q, b3_vld_q, vo_q;
  logic en1, en2, en3, en_o;

  logic signed [SUM_W-1:0] b1_sum_q, sum;
  nms_tag_t b1_tag_q, b2_tag_q, b3_tag_q, vo_tag_q;
  logic b2_neg_q, b3_neg_q;
  logic [M_W-1:0] b2_m_q, m_cap;
  logic [Q_W-1:0] b2_m10_q, b3_q_q, q_d, q_lim, q_sat;
  logic [SUM_W-1:0] mag;
  logic [EXT_W-1:0] mag_ext;
  logic [PRD_W-1:0] prod;
  logic signed [OUT_W-1:0] mean_q, mean_d;

  // Stage enables
  assign en_o  = !vo_q || out_ready_i;
  assign en3   = !b3_vld_q || en_o;
  assign en2   = !b2_vld_q || en3;
  assign en1   = !b1_vld_q || en2;
  assign pop_o = q_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
      vo_q     <= 1'b0;
    end else begin
      if (en1) b1_vld_q <= q_valid_i;
      if (en2) b2_vld_q <= b1_vld_q;
      if (en3) b3_vld_q <= b2_vld_q;
      if (en_o) vo_q <= b3_vld_q;
    end
  end

  // Sum of the eight masked neighbours
  always_comb begin
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + SUM_W'($signed(q_data_i[k*SB +: SB]));
    end
  end

  // Magnitude, capped where every count already saturates
  always_comb begin
    mag     = b1_sum_q[SUM_W-1] ? SUM_W'(-b1_sum_q) : SUM_W'(b1_sum_q);
    mag_ext = EXT_W'(mag);
    m_cap   = (mag_ext >= EXT_W'(MAG_CAP)) ? MAG_CAP : mag_ext[M_W-1:0];
  end

  // Rounded quotient per neighbour count
  always_comb begin
    prod = PRD_W'(b2_m10_q + Q_W'(1)) * PRD_W'(RECIP3);
    case (b2_tag_q.cnt)
      CNT_ONE:   q_d = b2_m10_q;
      CNT_TWO:   q_d = b2_m10_q >> 1;
      CNT_THREE: q_d = Q_W'(prod[PRD_W-1:RCP_SH]);
      CNT_FIVE:  q_d = Q_W'({b2_m_q, 1'b0});
      CNT_EIGHT: q_d = (b2_m10_q + Q_W'(4)) >> 3;
      default:   q_d = '0;
    endcase
  end

  // Sign and saturation to the result range
  always_comb begin
    q_lim  = b3_neg_q ? NEG_LIM : POS_LIM;
    q_sat  = (b3_q_q >= q_lim) ? q_lim : b3_q_q;
    mean_d = b3_neg_q ? OUT_W'(~q_sat + Q_W'(1)) : OUT_W'(q_sat);
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      b1_sum_q <= sum;
      b1_tag_q <= q_tag_i;
    end
    if (en2) begin
      b2_neg_q <= b1_sum_q[SUM_W-1];
      b2_m_q   <= m_cap;
      b2_m10_q <= (Q_W'(m_cap) << 3) + (Q_W'(m_cap) << 1);
      b2_tag_q <= b1_tag_q;
    end
    if (en3) begin
      b3_neg_q <= b2_neg_q;
      b3_q_q   <= q_d;
      b3_tag_q <= b2_tag_q;
    end
    if (en_o) begin
      mean_q   <= mean_d;
      vo_tag_q <= b3_tag_q;
    end
  end

  assign out_valid_o   = vo_q;
  assign mean_tenths_o = mean_q;
  assign out_row_o     = vo_tag_q.row;
  assign out_col_o     = vo_tag_q.col;
  assign frame_last_o  = vo_tag_q.last;

  // The last math stage holds while the output register is blocked
  a_b3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b3_vld_q && !en_o) |=> (b3_vld_q && $stable(b3_q_q)))
    else $error("quotient stage dropped a stalled transaction");

endmodule

// ===== bench/tb_neighbour_mean_smoothing_top.sv =====
// Self-checking testbench for the neighbour mean smoothing top level.
module tb_neighbour_mean_smoothing_top;
  import nms_pkg::*;

  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int          RANDOM_ITEMS  = 1300;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          END_CYCLES    = 32;
  localparam int          HOLD_AFTER    = 1500;
  localparam int          HOLD_CYCLES   = 3000;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          MAX_SHOWN     = 25;
  localparam longint      OUT_HI        = 524287;
  localparam longint      OUT_LO        = -524288;

  typedef enum logic [1:0] {STEP_ITEM, STEP_SETTLE, STEP_WRITE} step_kind_e;

  typedef struct {
    step_kind_e             kind;
    logic                   op;
    logic [SAMPLE_BITS-1:0] smp;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
  } stim_step_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } mean_rec_t;

  // DUT connections
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic                   op_i        = 1'b0;
  logic [SAMPLE_BITS-1:0] sample_i    = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [OUT_W-1:0]       mean_tenths_o;
  logic [POS_W-1:0]       out_row_o;
  logic [POS_W-1:0]       out_col_o;
  logic                   frame_last_o;

  // Stimulus plan and expected smoothed results
  stim_step_t stim_plan[$];
  mean_rec_t  pending_means[$];

  // Filter shadow state
  logic [CFG_W-1:0]              shadow_rows;
  logic [CFG_W-1:0]              shadow_cols;
  logic signed [SAMPLE_BITS-1:0] upper_line [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] middle_line [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] win [9];
  int unsigned                   feed_row;
  int unsigned                   feed_col;
  int unsigned                   emit_row;
  int unsigned                   emit_col;

  // Plan builder view of the frame size
  int unsigned gen_rows;
  int unsigned gen_cols;
  int          rnd_count;
  int          pick;
  int          part_len;

  // Bookkeeping
  int unsigned items_sent;
  int unsigned items_taken;
  int unsigned cfg_sent;
  int unsigned cfg_taken;
  int          results_seen;
  int          frames_seen;
  int          mismatches;
  int          cycle_count;

  // Driver and receiver state
  stim_step_t  cur_step;
  logic        nxt_in_valid;
  logic        nxt_cfg_valid;
  int          settle_left;
  int          gap_left;
  int          burst_left;
  logic        rx_ready_next;
  int          hold_left;
  bit          hold_done;
  int          rdy_mode;
  int          rdy_phase_left;
  int unsigned rdy_tick;

  // Monitor temporaries
  bit          got_mean;
  mean_rec_t   new_mean;
  mean_rec_t   want;

  neighbour_mean_smoothing_top #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_tenths_o(mean_tenths_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o)
  );

  // Clock and reset
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b0 | 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Filter prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void restart_positions();
    feed_row = 0;
    feed_col = 0;
    emit_row = 0;
    emit_col = 0;
  endfunction

  function automatic void clear_filter();
    shadow_rows = 1;
    shadow_cols = 1;
    foreach (upper_line[i]) upper_line[i] = '0;
    foreach (middle_line[i]) middle_line[i] = '0;
    foreach (win[i]) win[i] = '0;
    restart_positions();
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == REG_FRAME_ROWS) begin
      shadow_rows = data;
      restart_positions();
    end else if (idx == REG_FRAME_COLS) begin
      shadow_cols = data;
      restart_positions();
    end
  endfunction

  // Mean of the in-matrix neighbours of (er, ec); window column cc holds column ec
  function automatic logic [OUT_W-1:0] window_mean(int cc, int unsigned er, int unsigned ec,
                                                   int unsigned rows, int unsigned cols);
    longint          sum;
    longint          num;
    longint          res;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned cnt;
    longint          r;
    longint          c;
    int              wc;
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r  = longint'(er) + dr;
        c  = longint'(ec) + dc;
        wc = cc + dc;
        if (!(dr == 0 && dc == 0) && r >= 0 && r < longint'(rows) && c >= 0 &&
            c < longint'(cols) && wc >= 0 && wc <= 2) begin
          sum += longint'(win[(1 + dr) * 3 + wc]);
          cnt++;
        end
      end
    end
    if (cnt == 0) return '0;
    num = sum * 10;
    mag = (num < 0) ? -num : num;
    // round half away from zero on the magnitude
    q   = (2 * mag + cnt) / (2 * cnt);
    res = $signed(q);
    if (num < 0) res = -res;
    if (res > OUT_HI) res = OUT_HI;
    if (res < OUT_LO) res = OUT_LO;
    return res[OUT_W-1:0];
  endfunction

  // One accepted transaction: shift the window, update the line stores, maybe emit
  function automatic void smooth_step(logic op, logic [SAMPLE_BITS-1:0] smp,
                                      output bit has_res, output mean_rec_t rec);
    int unsigned             rows;
    int unsigned             cols;
    int unsigned             rr;
    int unsigned             cc;
    bit                      all_in;
    bit                      emit;
    logic signed [SAMPLE_BITS-1:0] val;
    logic [OUT_W-1:0]        mean;
    rows    = clamp_size(shadow_rows, MAX_ROWS);
    cols    = clamp_size(shadow_cols, MAX_COLS);
    all_in  = feed_row >= rows;
    has_res = 1'b0;
    rec     = '0;
    mean    = '0;
    // drain ahead of the last sample is ignored
    if (!all_in && op == OP_DRAIN) return;
    val = all_in ? '0 : smp;
    rr  = feed_row;
    cc  = (feed_col >= MAX_COLS) ? 0 : feed_col;
    emit = (rr >= 2) || (rr == 1 && cc >= 1);
    if (emit && cc == 0) mean = window_mean(2, emit_row, emit_col, rows, cols);
    for (int r = 0; r < 3; r++) begin
      win[r * 3]     = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = upper_line[cc];
    win[5] = middle_line[cc];
    win[8] = val;
    upper_line[cc]  = middle_line[cc];
    middle_line[cc] = val;
    if (emit && cc != 0) mean = window_mean(1, emit_row, emit_col, rows, cols);
    if (cc + 1 >= cols) begin
      feed_col = 0;
      feed_row = rr + 1;
    end else begin
      feed_col = cc + 1;
    end
    if (!emit) return;
    rec.mean = mean;
    rec.row  = emit_row[POS_W-1:0];
    rec.col  = emit_col[POS_W-1:0];
    rec.last = (emit_row + 1 >= rows) && (emit_col + 1 >= cols);
    has_res  = 1'b1;
    if (rec.last) begin
      restart_positions();
    end else if (emit_col + 1 >= cols) begin
      emit_col = 0;
      emit_row = emit_row + 1;
    end else begin
      emit_col = emit_col + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------

  function automatic void add_item(logic op, logic [SAMPLE_BITS-1:0] smp);
    stim_step_t s;
    s.kind = STEP_ITEM;
    s.op   = op;
    s.smp  = smp;
    s.idx  = '0;
    s.data = '0;
    stim_plan.push_back(s);
  endfunction

  function automatic void add_settle();
    stim_step_t s;
    s.kind = STEP_SETTLE;
    s.op   = OP_SAMPLE;
    s.smp  = '0;
    s.idx  = '0;
    s.data = '0;
    stim_plan.push_back(s);
  endfunction

  // Register writes only go out once the block has gone quiet
  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    stim_step_t s;
    add_settle();
    s.kind = STEP_WRITE;
    s.op   = OP_SAMPLE;
    s.smp  = '0;
    s.idx  = idx;
    s.data = val[CFG_W-1:0];
    stim_plan.push_back(s);
    if (idx == REG_FRAME_ROWS) gen_rows = clamp_size(val, MAX_ROWS);
    else gen_cols = clamp_size(val, MAX_COLS);
  endfunction

  // style: 0 full range, 1 tiny values (many rounding ties), 2 extremes, 3 walking bits
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int style);
    int val;
    case (style)
      0: val = $urandom;
      1: val = int'($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: val = 32'h7FFF;
          1: val = 32'h8000;
          2: val = 0;
          default: val = -1;
        endcase
      end
      default: begin
        val = 1 << $urandom_range(0, SAMPLE_BITS - 1);
        if ($urandom_range(0, 1) != 0) val = ~val;
      end
    endcase
    return val[SAMPLE_BITS-1:0];
  endfunction

  function automatic int unsigned pick_dim(int unsigned hi_small, int unsigned hi_big);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(hi_small + 1, hi_big);
    return $urandom_range(1, hi_small);
  endfunction

  // Full frame plus its tail; returns the number of transactions that count
  function automatic int add_frame(int style, int noise_pct, bit drain_tail);
    int total;
    total = gen_rows * gen_cols;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 99) < noise_pct) add_item(OP_DRAIN, $urandom);
      add_item(OP_SAMPLE, pick_sample(style));
    end
    // samples past the end of the frame behave as drains
    for (int i = 0; i <= int'(gen_cols); i++) begin
      if (drain_tail || $urandom_range(0, 1) == 0) add_item(OP_DRAIN, $urandom);
      else add_item(OP_SAMPLE, $urandom);
    end
    return total + gen_cols + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of transactions with random gaps
  // ---------------------------------------------------------------------------

  function automatic int pick_burst();
    if ($urandom_range(0, 9) == 0) return $urandom_range(200, 600);
    return $urandom_range(1, 40);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return $urandom_range(4, 12);
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // hold the bus while a transaction is still waiting for its handshake
      if (!((in_valid_i && items_sent != items_taken) ||
            (cfg_valid_i && cfg_sent != cfg_taken))) begin
        nxt_in_valid  = 1'b0;
        nxt_cfg_valid = 1'b0;
        if (settle_left > 0) begin
          if (pending_means.size() == 0) settle_left = settle_left - 1;
        end else if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (stim_plan.size() != 0) begin
          cur_step = stim_plan.pop_front();
          case (cur_step.kind)
            STEP_ITEM: begin
              nxt_in_valid = 1'b1;
              op_i        <= cur_step.op;
              sample_i    <= cur_step.smp;
              items_sent   = items_sent + 1;
              burst_left   = burst_left - 1;
              if (burst_left <= 0) begin
                burst_left = pick_burst();
                gap_left   = pick_gap();
              end
            end
            STEP_WRITE: begin
              nxt_cfg_valid = 1'b1;
              cfg_index_i  <= cur_step.idx;
              cfg_data_i   <= cur_step.data;
              cfg_sent      = cfg_sent + 1;
            end
            default: settle_left = SETTLE_CYCLES;
          endcase
        end
        in_valid_i  <= nxt_in_valid;
        cfg_valid_i <= nxt_cfg_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern plus one long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      rx_ready_next = 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done     = 1'b1;
      hold_left     = HOLD_CYCLES - 1;
      rx_ready_next = 1'b0;
    end else begin
      if (rdy_phase_left <= 0) begin
        rdy_mode       = $urandom_range(0, 3);
        rdy_phase_left = $urandom_range(20, 300);
      end
      rdy_phase_left = rdy_phase_left - 1;
      rdy_tick       = rdy_tick + 1;
      case (rdy_mode)
        0: rx_ready_next = 1'b1;
        1: rx_ready_next = ($urandom_range(0, 3) != 0);
        2: rx_ready_next = (rdy_tick % 3 == 0);
        default: rx_ready_next = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_ready_i <= rx_ready_next;
  end

  // ---------------------------------------------------------------------------
  // Monitor: track accepted transactions and check every result
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(string what);
    mismatches = mismatches + 1;
    if (mismatches <= MAX_SHOWN) $display("MISMATCH @%0d: %s", cycle_count, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_register(cfg_index_i, cfg_data_i);
        cfg_taken = cfg_taken + 1;
      end
      if (in_valid_i && in_ready_o) begin
        smooth_step(op_i, sample_i, got_mean, new_mean);
        if (got_mean) pending_means.push_back(new_mean);
        items_taken = items_taken + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_means.size() == 0) begin
          log_mismatch($sformatf("unexpected result row %0d col %0d mean %0d",
                                 out_row_o, out_col_o, $signed(mean_tenths_o)));
        end else begin
          want = pending_means.pop_front();
          if (mean_tenths_o !== want.mean)
            log_mismatch($sformatf("mean_tenths at (%0d,%0d): got %0d want %0d", want.row,
                                   want.col, $signed(mean_tenths_o), $signed(want.mean)));
          if (out_row_o !== want.row)
            log_mismatch($sformatf("out_row: got %0d want %0d", out_row_o, want.row));
          if (out_col_o !== want.col)
            log_mismatch($sformatf("out_col: got %0d want %0d", out_col_o, want.col));
          if (frame_last_o !== want.last)
            log_mismatch($sformatf("frame_last at (%0d,%0d): got %b want %b", want.row,
                                   want.col, frame_last_o, want.last));
        end
        results_seen = results_seen + 1;
        if (frame_last_o === 1'b1) frames_seen = frames_seen + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
               pending_means.size());
      $display("** neighbour_mean_smoothing_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------

  initial begin
    items_sent     = 0;
    items_taken    = 0;
    cfg_sent       = 0;
    cfg_taken      = 0;
    results_seen   = 0;
    frames_seen    = 0;
    mismatches     = 0;
    cycle_count    = 0;
    settle_left    = 0;
    gap_left       = 0;
    burst_left     = pick_burst();
    hold_left      = 0;
    hold_done      = 1'b0;
    rdy_mode       = 0;
    rdy_phase_left = 0;
    rdy_tick       = 0;
    clear_filter();
    gen_rows = 1;
    gen_cols = 1;

    // Reset size is 1x1: early drain ignored, lone sample gives a zero mean
    add_item(OP_DRAIN, 16'h1234);
    add_item(OP_SAMPLE, 16'h8000);
    add_item(OP_DRAIN, 16'h0000);
    add_item(OP_DRAIN, 16'hFFFF);

    // Partial 2x2 frame cut short by a register write
    add_write(REG_FRAME_ROWS, 2);
    add_write(REG_FRAME_COLS, 2);
    add_item(OP_SAMPLE, 16'h7FFF);
    add_item(OP_SAMPLE, 16'h7FFF);
    add_write(REG_FRAME_ROWS, 3);
    add_write(REG_FRAME_COLS, 3);

    // 3x3: centre neighbours sum to -2, a negative half that rounds to -3
    add_item(OP_SAMPLE, 16'hFFFF);
    add_item(OP_SAMPLE, 16'h0000);
    add_item(OP_SAMPLE, 16'h0000);
    add_item(OP_SAMPLE, 16'h0000);
    add_item(OP_SAMPLE, 16'h8000);
    add_item(OP_SAMPLE, 16'h0000);
    add_item(OP_SAMPLE, 16'h0000);
    add_item(OP_SAMPLE, 16'h0000);
    add_item(OP_SAMPLE, 16'hFFFF);
    add_item(OP_SAMPLE, 16'h7FFF);
    add_item(OP_SAMPLE, 16'h7FFF);
    add_item(OP_DRAIN, 16'h0000);
    add_item(OP_DRAIN, 16'h0000);

    // Size extremes: zero and oversized values clamp, full-width rows
    add_write(REG_FRAME_ROWS, 2047);
    add_write(REG_FRAME_COLS, 0);
    void'(add_frame(0, 0, 1'b1));
    add_write(REG_FRAME_ROWS, 0);
    add_write(REG_FRAME_COLS, 2047);
    void'(add_frame(0, 0, 1'b1));
    add_write(REG_FRAME_ROWS, 2);
    add_write(REG_FRAME_COLS, 1024);
    void'(add_frame(0, 5, 1'b0));
    add_write(REG_FRAME_ROWS, 1024);
    add_write(REG_FRAME_COLS, 2);
    void'(add_frame(2, 0, 1'b1));

    // Random frames, mostly small, with noise, aborts and pauses
    rnd_count = 0;
    while (rnd_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 2))
          0: begin
            add_write(REG_FRAME_ROWS, pick_dim(6, 20));
            add_write(REG_FRAME_COLS, pick_dim(8, 64));
          end
          1: add_write(REG_FRAME_ROWS, pick_dim(6, 20));
          default: add_write(REG_FRAME_COLS, pick_dim(8, 64));
        endcase
      end
      if ($urandom_range(0, 99) < 5) add_settle();
      if ($urandom_range(0, 99) < 8 && gen_rows * gen_cols > 1) begin
        // abandon the frame part way; the register write restarts it
        part_len = $urandom_range(1, gen_rows * gen_cols - 1);
        for (int i = 0; i < part_len; i++) begin
          if ($urandom_range(0, 9) == 0) add_item(OP_DRAIN, $urandom);
          add_item(OP_SAMPLE, pick_sample($urandom_range(0, 3)));
        end
        rnd_count += part_len;
        if ($urandom_range(0, 1) == 0) add_write(REG_FRAME_ROWS, pick_dim(6, 20));
        else add_write(REG_FRAME_COLS, pick_dim(8, 64));
      end else begin
        rnd_count += add_frame($urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? 10 : 0,
                               $urandom_range(0, 2) != 0);
      end
    end

    // Wait for the plan to go out and every expected result to come back
    while (stim_plan.size() != 0 || items_sent != items_taken || cfg_sent != cfg_taken ||
           settle_left != 0)
      @(posedge clk_i);
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Run covered %0d transactions, %0d register writes and %0d complete frames",
             items_taken, cfg_taken, frames_seen);
    $display("%0d smoothed results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** neighbour_mean_smoothing_top: PASSED **");
    end else begin
      $display("** neighbour_mean_smoothing_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/nms_pkg.sv
src/nms_queue.sv
src/nms_front.sv
src/nms_back.sv
src/neighbour_mean_smoothing_top.sv
bench/tb_neighbour_mean_smoothing_top.sv
